// ===== rtl/rrts_pkg.sv =====
// Shared types and reset constants of the round-robin thread scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   // Field widths of the request, response and register ports
   localparam int TID_W    = 4;
   localparam int QID_W    = 2;
   localparam int FUNC_W   = 3;
   localparam int WOKEN_W  = 5;
   localparam int STATUS_W = 3;

   // Register values after reset
   localparam logic [TID_W-1:0] IDLE_RESET = 4'd1;
   localparam logic [TID_W-1:0] BOOT_RESET = 4'd0;

   // Fields of one request
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [TID_W-1:0]  thread_id;
      logic [QID_W-1:0]  queue_id;
   } req_type;

   // Fields of one response, with its strobe
   typedef struct packed {
      logic                valid;
      logic [TID_W-1:0]    running_thread;
      logic [TID_W-1:0]    previous_thread;
      logic                switched;
      logic [WOKEN_W-1:0]  woken_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Register values in effect, and a restart pulse on any register write
   typedef struct packed {
      logic             restart;
      logic [TID_W-1:0] idle;
      logic [TID_W-1:0] boot;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler: registers, memories and sequencer.
//
// One request is taken when start is high and busy is low; its response appears
// on the rsp_ ports for exactly one cycle with rsp_valid high and must be taken
// then. Busy drops in the response cycle, so the next request may be issued
// there. Make ready, unused codes and failed checks end after decode; yield, block
// and exit may pass over idle, push it back and, for yield, push the previous one;
// wake one moves a thread and, if more wait, writes the new wait queue head; wake
// all repeats both steps until the queue is empty. The steps follow the link
// memory, a one-write, one-read RAM with a registered read: each list step is a
// dependent read and each run queue append is one write. Writing either register
// restarts the scheduler as at reset in the same cycle, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_thread_scheduler #(
   parameter int NUM_THREADS     = 16,
   parameter int NUM_WAIT_QUEUES = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [rrts_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [rrts_pkg::TID_W-1:0]        req_thread_id,
   input  wire logic [rrts_pkg::QID_W-1:0]        req_queue_id,
   output logic                                   rsp_valid,
   output logic [rrts_pkg::TID_W-1:0]             rsp_running_thread,
   output logic [rrts_pkg::TID_W-1:0]             rsp_previous_thread,
   output logic                                   rsp_switched,
   output logic [rrts_pkg::WOKEN_W-1:0]           rsp_woken_count,
   output logic [rrts_pkg::STATUS_W-1:0]          rsp_status,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [rrts_pkg::TID_W-1:0]        csr_data
);

   localparam int TW = $clog2(NUM_THREADS);
   localparam int QW = (NUM_WAIT_QUEUES > 1) ? $clog2(NUM_WAIT_QUEUES) : 1;

   // Register indexes
   localparam logic CSR_IDLE = 1'b0;
   localparam logic CSR_BOOT = 1'b1;

   logic [rrts_pkg::TID_W-1:0] idle_ff, idle_in;
   logic [rrts_pkg::TID_W-1:0] boot_ff, boot_in;

   rrts_pkg::cfg_type cfg;
   rrts_pkg::req_type req;
   rrts_pkg::rsp_type rsp;

   logic            link_we;
   logic [TW-1:0]   link_waddr;
   logic [TW-1:0]   link_wdata;
   logic [TW-1:0]   link_raddr;
   logic [TW-1:0]   link_rdata;
   logic            wq_we;
   logic [QW-1:0]   wq_addr_w;
   logic [2*TW-1:0] wq_wdata;
   logic [QW-1:0]   wq_addr_r;
   logic [2*TW-1:0] wq_rdata;

   // Decode register writes
   always_comb begin
      idle_in = idle_ff;
      boot_in = boot_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE: idle_in = csr_data;
            CSR_BOOT: boot_in = csr_data;
         endcase
      end
   end

   // Hold the register values
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= rrts_pkg::IDLE_RESET;
         boot_ff <= rrts_pkg::BOOT_RESET;
      end else begin
         idle_ff <= idle_in;
         boot_ff <= boot_in;
      end
   end

   assign cfg.restart   = csr_we;
   assign cfg.idle      = idle_in;
   assign cfg.boot      = boot_in;

   assign req.func      = req_func;
   assign req.thread_id = req_thread_id;
   assign req.queue_id  = req_queue_id;

   assign rsp_valid           = rsp.valid;
   assign rsp_running_thread  = rsp.running_thread;
   assign rsp_previous_thread = rsp.previous_thread;
   assign rsp_switched        = rsp.switched;
   assign rsp_woken_count     = rsp.woken_count;
   assign rsp_status          = rsp.status;

   // Next-thread links shared by the run queue and the wait queues
   rrts_ram #(
      .WIDTH (TW),
      .DEPTH (NUM_THREADS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // Head and tail of each wait queue
   rrts_ram #(
      .WIDTH (2 * TW),
      .DEPTH (NUM_WAIT_QUEUES)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wq_we),
      .wr_addr (wq_addr_w),
      .wr_data (wq_wdata),
      .rd_addr (wq_addr_r),
      .rd_data (wq_rdata)
   );

   rrts_seq #(
      .NUM_THREADS     (NUM_THREADS),
      .NUM_WAIT_QUEUES (NUM_WAIT_QUEUES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start      (start),
      .req        (req),
      .busy       (busy),
      .rsp        (rsp),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata),
      .wq_we      (wq_we),
      .wq_addr_w  (wq_addr_w),
      .wq_wdata   (wq_wdata),
      .wq_addr_r  (wq_addr_r),
      .wq_rdata   (wq_rdata)
   );

endmodule

`default_nettype wire

// ===== rtl/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/rrts_seq.sv =====
// Operation sequencer: run queue and wait queue control over the link and wait memories.
`timescale 1ns / 1ps
`default_nettype none

module rrts_seq #(
   parameter int NUM_THREADS     = 16,
   parameter int NUM_WAIT_QUEUES = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rrts_pkg::cfg_type             cfg,
   input  wire logic                          start,
   input  wire rrts_pkg::req_type             req,
   output logic                               busy,
   output rrts_pkg::rsp_type                  rsp,
   // link memory: one next-thread entry per thread
   output logic                               link_we,
   output logic [$clog2(NUM_THREADS)-1:0]     link_waddr,
   output logic [$clog2(NUM_THREADS)-1:0]     link_wdata,
   output logic [$clog2(NUM_THREADS)-1:0]     link_raddr,
   input  wire logic [$clog2(NUM_THREADS)-1:0] link_rdata,
   // wait memory: head and tail per wait queue
   output logic                               wq_we,
   output logic [((NUM_WAIT_QUEUES > 1) ? $clog2(NUM_WAIT_QUEUES) : 1)-1:0] wq_addr_w,
   output logic [2*$clog2(NUM_THREADS)-1:0]   wq_wdata,
   output logic [((NUM_WAIT_QUEUES > 1) ? $clog2(NUM_WAIT_QUEUES) : 1)-1:0] wq_addr_r,
   input  wire logic [2*$clog2(NUM_THREADS)-1:0] wq_rdata
);

   localparam int TW    = $clog2(NUM_THREADS);
   localparam int QW    = (NUM_WAIT_QUEUES > 1) ? $clog2(NUM_WAIT_QUEUES) : 1;
   localparam int WCW   = $clog2(NUM_THREADS + 1);
   localparam int TID_N = 1 << rrts_pkg::TID_W;
   localparam int QID_N = 1 << rrts_pkg::QID_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DEC       = 3'd1;
   localparam logic [2:0] S_E2        = 3'd2;
   localparam logic [2:0] S_PUSH_IDLE = 3'd3;
   localparam logic [2:0] S_PUSH_PREV = 3'd4;
   localparam logic [2:0] S_WPOP      = 3'd5;
   localparam logic [2:0] S_WNEXT     = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   // Operation codes
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_READY   = 3'd0;
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_YIELD   = 3'd1;
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_BLOCK   = 3'd2;
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_WAKE1   = 3'd3;
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_WAKEALL = 3'd4;
   localparam logic [rrts_pkg::FUNC_W-1:0] FN_EXIT    = 3'd5;

   // Status codes
   localparam logic [rrts_pkg::STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [rrts_pkg::STATUS_W-1:0] ST_LINKED   = 3'd1;
   localparam logic [rrts_pkg::STATUS_W-1:0] ST_NO_RUN   = 3'd2;
   localparam logic [rrts_pkg::STATUS_W-1:0] ST_IDLE_BLK = 3'd3;
   localparam logic [rrts_pkg::STATUS_W-1:0] ST_WQ_EMPTY = 3'd4;

   // Fold field values into the thread and queue ranges
   logic [TW-1:0] tmod [TID_N];
   logic [QW-1:0] qmod [QID_N];

   genvar g;
   for (g = 0; g < TID_N; g++) begin : g_tmod
      assign tmod[g] = TW'(g % NUM_THREADS);
   end
   for (g = 0; g < QID_N; g++) begin : g_qmod
      assign qmod[g] = QW'(g % NUM_WAIT_QUEUES);
   end

   // Control state
   logic [2:0]             state_ff, state_in;
   logic [TW-1:0]          cur_ff, cur_in;
   logic [TW-1:0]          head_ff, head_in;
   logic [TW-1:0]          tail_ff, tail_in;
   logic                   rne_ff, rne_in;
   logic [NUM_THREADS-1:0] linked_ff, linked_in;
   logic [NUM_WAIT_QUEUES-1:0] wne_ff, wne_in;

   // Per-operation payload
   logic [rrts_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [TW-1:0]                 tid_ff, tid_in;
   logic [QW-1:0]                 q_ff, q_in;
   logic [TW-1:0]                 prev_ff, prev_in;
   logic [TW-1:0]                 wh_ff, wh_in;
   logic [TW-1:0]                 wt_ff, wt_in;
   logic [WCW-1:0]                woken_ff, woken_in;
   logic [rrts_pkg::STATUS_W-1:0] status_ff, status_in;

   logic                   accept;
   logic [TW-1:0]          idle_t;
   logic [TW-1:0]          start_idle;
   logic [TW-1:0]          start_boot;
   logic [NUM_THREADS-1:0] linked_start;
   logic                   push_en;
   logic [TW-1:0]          push_t;
   logic                   do_pop;
   logic                   skip;
   logic [TW-1:0]          wq_head;
   logic [TW-1:0]          wq_tail;

   assign idle_t  = tmod[cfg.idle];
   assign wq_head = wq_rdata[2*TW-1:TW];
   assign wq_tail = wq_rdata[TW-1:0];
   assign busy    = (state_ff != S_IDLE) && (state_ff != S_DONE);
   assign accept  = start && !busy;

   // Start state: boot running, idle alone on the run queue unless it is boot
   always_comb begin
      start_idle   = reset ? tmod[rrts_pkg::IDLE_RESET] : tmod[cfg.idle];
      start_boot   = reset ? tmod[rrts_pkg::BOOT_RESET] : tmod[cfg.boot];
      linked_start = '0;
      linked_start[start_idle] = (start_boot != start_idle);
   end

   // Next-state logic of the sequencer
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      rne_in     = rne_ff;
      linked_in  = linked_ff;
      wne_in     = wne_ff;
      func_in    = func_ff;
      tid_in     = tid_ff;
      q_in       = q_ff;
      prev_in    = prev_ff;
      wh_in      = wh_ff;
      wt_in      = wt_ff;
      woken_in   = woken_ff;
      status_in  = status_ff;
      link_we    = 1'b0;
      link_waddr = tail_ff;
      link_wdata = prev_ff;
      link_raddr = head_ff;
      wq_we      = 1'b0;
      wq_addr_w  = q_ff;
      wq_wdata   = {prev_ff, prev_ff};
      wq_addr_r  = q_ff;
      push_en    = 1'b0;
      push_t     = prev_ff;
      do_pop     = 1'b0;
      skip       = (head_ff == idle_t) && (head_ff != tail_ff);

      unique case (state_ff) inside
         S_IDLE, S_DONE: begin
            // Take a request; fetch its wait queue and the run queue's second entry
            wq_addr_r = qmod[req.queue_id];
            if (accept) begin
               state_in  = S_DEC;
               func_in   = req.func;
               tid_in    = tmod[req.thread_id];
               q_in      = qmod[req.queue_id];
               prev_in   = cur_ff;
               woken_in  = '0;
               status_in = ST_OK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DEC: begin
            state_in = S_DONE;
            unique case (func_ff) inside
               FN_READY: begin
                  if (linked_ff[tid_ff]) begin
                     status_in = ST_LINKED;
                  end else begin
                     push_en = 1'b1;
                     push_t  = tid_ff;
                  end
               end
               FN_YIELD: begin
                  // Idle alone on the run queue: nothing to switch to
                  if (linked_ff[prev_ff]) begin
                     status_in = ST_LINKED;
                  end else if (rne_ff &&
                               !((head_ff == idle_t) && (head_ff == tail_ff))) begin
                     do_pop = 1'b1;
                  end
               end
               FN_BLOCK: begin
                  if (prev_ff == idle_t) begin
                     status_in = ST_IDLE_BLK;
                  end else if (linked_ff[prev_ff]) begin
                     status_in = ST_LINKED;
                  end else if (!rne_ff) begin
                     status_in = ST_NO_RUN;
                  end else begin
                     // Append current thread to the wait queue
                     wq_we              = 1'b1;
                     wq_wdata           = {wne_ff[q_ff] ? wq_head : prev_ff, prev_ff};
                     link_we            = wne_ff[q_ff];
                     link_waddr         = wq_tail;
                     link_wdata         = prev_ff;
                     linked_in[prev_ff] = 1'b1;
                     wne_in[q_ff]       = 1'b1;
                     do_pop             = 1'b1;
                  end
               end
               FN_WAKE1, FN_WAKEALL: begin
                  if (!wne_ff[q_ff]) begin
                     status_in = ST_WQ_EMPTY;
                  end else begin
                     wh_in    = wq_head;
                     wt_in    = wq_tail;
                     state_in = S_WPOP;
                  end
               end
               FN_EXIT: begin
                  if (!rne_ff) begin
                     status_in = ST_NO_RUN;
                  end else begin
                     do_pop = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            // Pop the next thread, passing over idle when another one waits
            if (do_pop) begin
               if (skip) begin
                  cur_in                = link_rdata;
                  linked_in[link_rdata] = 1'b0;
                  if (link_rdata == tail_ff) begin
                     rne_in   = 1'b0;
                     state_in = S_PUSH_IDLE;
                  end else begin
                     link_raddr = link_rdata;
                     state_in   = S_E2;
                  end
               end else begin
                  cur_in             = head_ff;
                  linked_in[head_ff] = 1'b0;
                  if (head_ff == tail_ff) begin
                     rne_in = 1'b0;
                  end else begin
                     head_in = link_rdata;
                  end
                  state_in = (func_ff == FN_YIELD) ? S_PUSH_PREV : S_DONE;
               end
            end
         end
         S_E2: begin
            // Third entry becomes the head
            head_in  = link_rdata;
            state_in = S_PUSH_IDLE;
         end
         S_PUSH_IDLE: begin
            push_en  = 1'b1;
            push_t   = idle_t;
            state_in = (func_ff == FN_YIELD) ? S_PUSH_PREV : S_DONE;
         end
         S_PUSH_PREV: begin
            push_en  = 1'b1;
            push_t   = prev_ff;
            state_in = S_DONE;
         end
         S_WPOP: begin
            // Move the wait queue head to the run queue tail
            push_en  = 1'b1;
            push_t   = wh_ff;
            woken_in = woken_ff + WCW'(1);
            if (wh_ff == wt_ff) begin
               wne_in[q_ff] = 1'b0;
               state_in     = S_DONE;
            end else begin
               link_raddr = wh_ff;
               state_in   = S_WNEXT;
            end
         end
         S_WNEXT: begin
            // Advance the wait queue head; wake-one writes it back and stops
            wh_in = link_rdata;
            if (func_ff == FN_WAKE1) begin
               wq_we    = 1'b1;
               wq_wdata = {link_rdata, wt_ff};
               state_in = S_DONE;
            end else begin
               state_in = S_WPOP;
            end
         end
      endcase

      // Append one thread to the run queue; the tail's link lives in head_ff
      if (push_en) begin
         linked_in[push_t] = 1'b1;
         if (rne_ff) begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = push_t;
            tail_in    = push_t;
         end else begin
            head_in = push_t;
            tail_in = push_t;
            rne_in  = 1'b1;
         end
      end
   end

   // Control registers: restart on reset and on any register write
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         state_ff  <= S_IDLE;
         cur_ff    <= start_boot;
         head_ff   <= start_idle;
         tail_ff   <= start_idle;
         rne_ff    <= (start_boot != start_idle);
         linked_ff <= linked_start;
         wne_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cur_ff    <= cur_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         rne_ff    <= rne_in;
         linked_ff <= linked_in;
         wne_ff    <= wne_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      tid_ff    <= tid_in;
      q_ff      <= q_in;
      prev_ff   <= prev_in;
      wh_ff     <= wh_in;
      wt_ff     <= wt_in;
      woken_ff  <= woken_in;
      status_ff <= status_in;
   end

   // Present the response for the one cycle spent in S_DONE
   always_comb begin
      rsp.valid           = (state_ff == S_DONE);
      rsp.running_thread  = rrts_pkg::TID_W'(cur_ff);
      rsp.previous_thread = rrts_pkg::TID_W'(prev_ff);
      rsp.switched        = (cur_ff != prev_ff);
      rsp.woken_count     = rrts_pkg::WOKEN_W'(woken_ff);
      rsp.status          = status_ff;
   end

endmodule

`default_nettype wire

// ===== sim/tb_round_robin_thread_scheduler.sv =====
// Self-checking testbench for the round-robin thread scheduler: directed table plus random requests.
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;

   localparam int NUM_T     = 16;
   localparam int NUM_Q     = 4;
   localparam int DIR_N     = 25;
   localparam int PHASE_N   = 5;
   localparam int PHASE_LEN = 95;

   typedef logic [rrts_pkg::TID_W-1:0]   tid_type;
   typedef logic [rrts_pkg::QID_W-1:0]   qid_type;
   typedef logic [rrts_pkg::WOKEN_W-1:0] woken_type;

   typedef enum logic [rrts_pkg::FUNC_W-1:0] {
      OP_READY    = 3'd0,
      OP_YIELD    = 3'd1,
      OP_BLOCK    = 3'd2,
      OP_WAKE_ONE = 3'd3,
      OP_WAKE_ALL = 3'd4,
      OP_EXIT     = 3'd5,
      OP_RSVD6    = 3'd6,
      OP_RSVD7    = 3'd7
   } sched_op_type;

   typedef enum logic [rrts_pkg::STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_LINKED      = 3'd1,
      ST_NO_RUNNABLE = 3'd2,
      ST_IDLE_BLOCK  = 3'd3,
      ST_WAIT_EMPTY  = 3'd4
   } sched_status_type;

   localparam logic REG_IDLE = 1'b0;
   localparam logic REG_BOOT = 1'b1;

   // Idling modes of the request side
   localparam int GAP_NONE = 0;
   localparam int GAP_HIGH = 1;
   localparam int GAP_LOW  = 2;

   // One row of the directed table; run..st are used only where typed is set
   typedef struct packed {
      sched_op_type     op;
      tid_type          tid;
      qid_type          qid;
      logic             typed;
      tid_type          run;
      tid_type          prev;
      logic             sw;
      woken_type        woken;
      sched_status_type st;
   } dir_row_type;

   // Rows run from the reset settings: idle thread 1, boot thread 0
   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      // yield with only idle ready: no switch
      '{OP_YIELD,    4'd0,  2'd0, 1'b1, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      // block boot: fall back to idle
      '{OP_BLOCK,    4'd0,  2'd0, 1'b1, 4'd1,  4'd0,  1'b1, 5'd0, ST_OK},
      // idle may not block
      '{OP_BLOCK,    4'd0,  2'd1, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_IDLE_BLOCK},
      // exit with run queue empty
      '{OP_EXIT,     4'd0,  2'd0, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_NO_RUNNABLE},
      // wakes on empty wait queues
      '{OP_WAKE_ONE, 4'd0,  2'd2, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_WAIT_EMPTY},
      '{OP_WAKE_ALL, 4'd0,  2'd3, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_WAIT_EMPTY},
      // make ready, then again while linked; thread 0 sits on a wait queue
      '{OP_READY,    4'd15, 2'd0, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_OK},
      '{OP_READY,    4'd15, 2'd0, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_LINKED},
      '{OP_READY,    4'd0,  2'd0, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_LINKED},
      // unused codes change nothing
      '{OP_RSVD6,    4'd0,  2'd0, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_OK},
      '{OP_RSVD7,    4'd15, 2'd3, 1'b1, 4'd1,  4'd1,  1'b0, 5'd0, ST_OK},
      // idle yields to 15
      '{OP_YIELD,    4'd0,  2'd0, 1'b1, 4'd15, 4'd1,  1'b1, 5'd0, ST_OK},
      // running thread made ready, then yield and block while linked
      '{OP_READY,    4'd15, 2'd0, 1'b1, 4'd15, 4'd15, 1'b0, 5'd0, ST_OK},
      '{OP_YIELD,    4'd0,  2'd0, 1'b1, 4'd15, 4'd15, 1'b0, 5'd0, ST_LINKED},
      '{OP_BLOCK,    4'd0,  2'd0, 1'b1, 4'd15, 4'd15, 1'b0, 5'd0, ST_LINKED},
      // exit while queued: the thread is picked again
      '{OP_EXIT,     4'd0,  2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_READY,    4'd14, 2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_READY,    4'd13, 2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_BLOCK,    4'd0,  2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_BLOCK,    4'd0,  2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_WAKE_ONE, 4'd0,  2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_WAKE_ALL, 4'd0,  2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_BLOCK,    4'd0,  2'd3, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_WAKE_ALL, 4'd0,  2'd3, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK},
      '{OP_EXIT,     4'd0,  2'd0, 1'b0, 4'd0,  4'd0,  1'b0, 5'd0, ST_OK}
   };

   // Register settings per random phase; a negative value means pick at random
   localparam int PHASE_IDLE [PHASE_N] = '{0, 15, 5, -1, -1};
   localparam int PHASE_BOOT [PHASE_N] = '{15, 0, 5, -1, -1};
   localparam int PHASE_GAP  [PHASE_N] = '{GAP_NONE, GAP_HIGH, GAP_LOW, GAP_HIGH, GAP_NONE};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic [rrts_pkg::FUNC_W-1:0] req_func = '0;
   tid_type   req_thread_id = '0;
   qid_type   req_queue_id = '0;
   logic      rsp_valid;
   tid_type   rsp_running_thread;
   tid_type   rsp_previous_thread;
   logic      rsp_switched;
   woken_type rsp_woken_count;
   logic [rrts_pkg::STATUS_W-1:0] rsp_status;
   logic      csr_we = 1'b0;
   logic      csr_index = 1'b0;
   tid_type   csr_data = '0;

   round_robin_thread_scheduler dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_thread_id       (req_thread_id),
      .req_queue_id        (req_queue_id),
      .rsp_valid           (rsp_valid),
      .rsp_running_thread  (rsp_running_thread),
      .rsp_previous_thread (rsp_previous_thread),
      .rsp_switched        (rsp_switched),
      .rsp_woken_count     (rsp_woken_count),
      .rsp_status          (rsp_status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("round_robin_thread_scheduler verification failed");
      $finish;
   end

   // Scheduler shadow state; per-thread states are not visible at the ports,
   // so only the lists are tracked
   tid_type cfg_idle;
   tid_type cfg_boot;
   tid_type cur_thread;
   tid_type run_tail;
   logic    run_ne;
   tid_type link_nxt [NUM_T];
   logic    linked   [NUM_T];
   tid_type wq_head  [NUM_Q];
   tid_type wq_tail  [NUM_Q];
   logic    wq_ne    [NUM_Q];

   rrts_pkg::rsp_type sched_pending [$];

   int err_count = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_switch = 0;
   int n_woken = 0;
   int n_err_status = 0;
   int n_settings = 1;

   // Restart the lists, as a reset or any register write does
   function automatic void restart_sched();
      for (int i = 0; i < NUM_T; i++) begin
         link_nxt[i] = '0;
         linked[i] = 1'b0;
      end
      for (int i = 0; i < NUM_Q; i++) begin
         wq_head[i] = '0;
         wq_tail[i] = '0;
         wq_ne[i] = 1'b0;
      end
      cur_thread = cfg_boot;
      run_tail = cfg_idle;
      if (cfg_boot == cfg_idle) begin
         run_ne = 1'b0;
      end else begin
         run_ne = 1'b1;
         link_nxt[cfg_idle] = cfg_idle;
         linked[cfg_idle] = 1'b1;
      end
   endfunction

   // Append a thread at the tail of the circular run queue
   function automatic void run_append(input tid_type t);
      linked[t] = 1'b1;
      if (!run_ne) begin
         run_tail = t;
         link_nxt[t] = t;
         run_ne = 1'b1;
      end else begin
         link_nxt[t] = link_nxt[run_tail];
         link_nxt[run_tail] = t;
         run_tail = t;
      end
   endfunction

   function automatic bit run_take(output tid_type t);
      tid_type head;
      if (!run_ne) return 1'b0;
      head = link_nxt[run_tail];
      if (head == run_tail) run_ne = 1'b0;
      else link_nxt[run_tail] = link_nxt[head];
      linked[head] = 1'b0;
      t = head;
      return 1'b1;
   endfunction

   // Pass over the idle thread, sending it back to the tail
   function automatic bit run_take_skip_idle(output tid_type t);
      tid_type lead;
      bit      got;
      if (!run_take(lead)) return 1'b0;
      if (lead != cfg_idle) begin
         t = lead;
         return 1'b1;
      end
      got = run_take(t);
      run_append(lead);
      return got;
   endfunction

   function automatic bit run_take_any(output tid_type t);
      if (run_take_skip_idle(t)) return 1'b1;
      return run_take(t);
   endfunction

   function automatic bit wait_take(input qid_type q, output tid_type t);
      tid_type head;
      if (!wq_ne[q]) return 1'b0;
      head = wq_head[q];
      if (head == wq_tail[q]) wq_ne[q] = 1'b0;
      else wq_head[q] = link_nxt[head];
      linked[head] = 1'b0;
      t = head;
      return 1'b1;
   endfunction

   // Apply one request to the shadow state and return its response
   function automatic rrts_pkg::rsp_type predict_op(input rrts_pkg::req_type r);
      tid_type           prev;
      tid_type           nxt;
      tid_type           t;
      int                woken;
      sched_status_type  st;
      rrts_pkg::rsp_type res;
      prev = cur_thread;
      woken = 0;
      st = ST_OK;
      case (sched_op_type'(r.func))
         OP_READY: begin
            if (linked[r.thread_id]) st = ST_LINKED;
            else run_append(r.thread_id);
         end
         OP_YIELD: begin
            if (linked[prev]) begin
               st = ST_LINKED;
            end else if (run_take_skip_idle(nxt)) begin
               run_append(prev);
               cur_thread = nxt;
            end
         end
         OP_BLOCK: begin
            if (prev == cfg_idle) begin
               st = ST_IDLE_BLOCK;
            end else if (linked[prev]) begin
               st = ST_LINKED;
            end else if (!run_ne) begin
               st = ST_NO_RUNNABLE;
            end else begin
               linked[prev] = 1'b1;
               if (!wq_ne[r.queue_id]) wq_head[r.queue_id] = prev;
               else link_nxt[wq_tail[r.queue_id]] = prev;
               wq_tail[r.queue_id] = prev;
               wq_ne[r.queue_id] = 1'b1;
               if (run_take_any(nxt)) cur_thread = nxt;
            end
         end
         OP_WAKE_ONE: begin
            if (wait_take(r.queue_id, t)) begin
               run_append(t);
               woken = 1;
            end else begin
               st = ST_WAIT_EMPTY;
            end
         end
         OP_WAKE_ALL: begin
            if (!wq_ne[r.queue_id]) st = ST_WAIT_EMPTY;
            for (int i = 0; i < NUM_T; i++) begin
               if (!wait_take(r.queue_id, t)) break;
               run_append(t);
               woken++;
            end
         end
         OP_EXIT: begin
            if (!run_ne) st = ST_NO_RUNNABLE;
            else if (run_take_any(nxt)) cur_thread = nxt;
         end
         default: begin
         end
      endcase
      res.valid = 1'b1;
      res.running_thread = cur_thread;
      res.previous_thread = prev;
      res.switched = (cur_thread != prev);
      res.woken_count = woken_type'(woken);
      res.status = st;
      return res;
   endfunction

   // Prefer a thread that is on no list, so make-ready mostly succeeds
   function automatic tid_type pick_unlinked();
      int      base;
      tid_type t;
      base = $urandom_range(0, NUM_T - 1);
      for (int i = 0; i < NUM_T; i++) begin
         t = tid_type'((base + i) % NUM_T);
         if (!linked[t] && t != cur_thread) return t;
      end
      return tid_type'(base);
   endfunction

   function automatic qid_type pick_waiting();
      int      base;
      qid_type q;
      base = $urandom_range(0, NUM_Q - 1);
      for (int i = 0; i < NUM_Q; i++) begin
         q = qid_type'((base + i) % NUM_Q);
         if (wq_ne[q]) return q;
      end
      return qid_type'(base);
   endfunction

   function automatic rrts_pkg::req_type random_request();
      rrts_pkg::req_type r;
      int                pick;
      pick = $urandom_range(0, 99);
      r.thread_id = tid_type'($urandom_range(0, NUM_T - 1));
      r.queue_id = qid_type'($urandom_range(0, NUM_Q - 1));
      if (pick < 24) begin
         r.func = OP_READY;
         if ($urandom_range(0, 3) != 0) r.thread_id = pick_unlinked();
      end else if (pick < 44) begin
         r.func = OP_YIELD;
      end else if (pick < 60) begin
         r.func = OP_BLOCK;
      end else if (pick < 72) begin
         r.func = OP_WAKE_ONE;
         if ($urandom_range(0, 9) < 7) r.queue_id = pick_waiting();
      end else if (pick < 84) begin
         r.func = OP_WAKE_ALL;
         if ($urandom_range(0, 9) < 7) r.queue_id = pick_waiting();
      end else if (pick < 95) begin
         r.func = OP_EXIT;
      end else begin
         r.func = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
      end
      return r;
   endfunction

   // Idle cycles before the next request: each cycle idles with the mode's odds
   function automatic int gap_cycles(input int mode);
      int pct;
      int n;
      pct = (mode == GAP_HIGH) ? 71 : (mode == GAP_LOW) ? 23 : 0;
      n = 0;
      while (n < 40 && $urandom_range(0, 99) < pct) n++;
      return n;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (response %0d)", what, got, want,
               n_checked);
      err_count++;
   endtask

   // Issue one request and hold it until accepted; start stays high afterwards
   task automatic send_req(input rrts_pkg::req_type r, input bit typed,
                           input rrts_pkg::rsp_type want);
      rrts_pkg::rsp_type exp;
      start <= 1'b1;
      req_func <= r.func;
      req_thread_id <= r.thread_id;
      req_queue_id <= r.queue_id;
      do @(posedge clock); while (busy);
      exp = predict_op(r);
      if (typed) exp = want;
      sched_pending.push_back(exp);
      n_sent++;
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Wait until every response is back and the block is free
   task automatic drain();
      while (sched_pending.size() != 0 || busy) @(posedge clock);
      @(posedge clock);
   endtask

   // Write both registers back to back; each write restarts the scheduler
   task automatic program_regs(input tid_type idle_val, input tid_type boot_val);
      csr_we <= 1'b1;
      csr_index <= REG_IDLE;
      csr_data <= idle_val;
      @(posedge clock);
      cfg_idle = idle_val;
      restart_sched();
      csr_index <= REG_BOOT;
      csr_data <= boot_val;
      @(posedge clock);
      cfg_boot = boot_val;
      restart_sched();
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // Compare each response against the oldest expectation
   always @(posedge clock) begin : check_rsp
      rrts_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (sched_pending.size() == 0) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            want = sched_pending.pop_front();
            if (rsp_running_thread !== want.running_thread)
               report_mismatch("running_thread", int'(rsp_running_thread),
                               int'(want.running_thread));
            if (rsp_previous_thread !== want.previous_thread)
               report_mismatch("previous_thread", int'(rsp_previous_thread),
                               int'(want.previous_thread));
            if (rsp_switched !== want.switched)
               report_mismatch("switched", int'(rsp_switched), int'(want.switched));
            if (rsp_woken_count !== want.woken_count)
               report_mismatch("woken_count", int'(rsp_woken_count),
                               int'(want.woken_count));
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
         end
         n_checked++;
         if (rsp_switched === 1'b1) n_switch++;
         n_woken += int'(rsp_woken_count);
         if (rsp_status !== ST_OK) n_err_status++;
      end
   end

   initial begin : stimulus
      rrts_pkg::req_type r;
      rrts_pkg::rsp_type want;
      tid_type           idle_val;
      tid_type           boot_val;
      cfg_idle = rrts_pkg::IDLE_RESET;
      cfg_boot = rrts_pkg::BOOT_RESET;
      restart_sched();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, back to back
      for (int i = 0; i < DIR_N; i++) begin
         r.func = DIR_ROWS[i].op;
         r.thread_id = DIR_ROWS[i].tid;
         r.queue_id = DIR_ROWS[i].qid;
         want.valid = 1'b1;
         want.running_thread = DIR_ROWS[i].run;
         want.previous_thread = DIR_ROWS[i].prev;
         want.switched = DIR_ROWS[i].sw;
         want.woken_count = DIR_ROWS[i].woken;
         want.status = DIR_ROWS[i].st;
         send_req(r, DIR_ROWS[i].typed, want);
      end
      start <= 1'b0;
      drain();

      // Random phases, each under fresh register settings
      for (int p = 0; p < PHASE_N; p++) begin
         idle_val = (PHASE_IDLE[p] < 0) ? tid_type'($urandom_range(0, NUM_T - 1))
                                        : tid_type'(PHASE_IDLE[p]);
         boot_val = (PHASE_BOOT[p] < 0) ? tid_type'($urandom_range(0, NUM_T - 1))
                                        : tid_type'(PHASE_BOOT[p]);
         program_regs(idle_val, boot_val);
         for (int k = 0; k < PHASE_LEN; k++) begin
            send_req(random_request(), 1'b0, '0);
            hold_off(gap_cycles(PHASE_GAP[p]));
         end
         start <= 1'b0;
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d requests under %0d register settings; %0d responses compared.",
               n_sent, n_settings, n_checked);
      $display("Saw %0d context switches, %0d threads woken, %0d error statuses.",
               n_switch, n_woken, n_err_status);
      if (err_count == 0) begin
         $display("round_robin_thread_scheduler verification clean");
      end else begin
         $display("round_robin_thread_scheduler verification failed");
      end
      $finish;
   end

endmodule
